// File: src/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg
// Types and defaults shared by the key/value table and its entry store.
// ----------------------------------------------------------------------------
package kvt_pkg;

  localparam int KVT_ENTRIES    = 64;
  localparam int KVT_KEY_BITS   = 64;
  localparam int KVT_VALUE_BITS = 64;

  // Width of the key and value words on the ports.
  localparam int KVT_FIELD_W = 64;

  typedef enum logic [1:0] {
    KVT_SET = 2'd0,
    KVT_GET = 2'd1,
    KVT_DEL = 2'd2
  } kvt_func_t;

  // Write request from the sequencer to the entry store.
  typedef struct packed {
    logic                   tag_en;
    logic                   val_en;
    logic                   valid;
    logic [KVT_FIELD_W-1:0] key;
    logic [KVT_FIELD_W-1:0] value;
  } kvt_wr_t;

  // Result of comparing one stored entry against the request key.
  typedef struct packed {
    logic hit;
    logic free;
  } kvt_cmp_t;

endpackage

// File: src/kvt_store.sv
// ----------------------------------------------------------------------------
// kvt_store
// Entry storage (valid mark and key, value) with one write port, one
// registered read port and the shared key comparator.
// ----------------------------------------------------------------------------
module kvt_store
  import kvt_pkg::*;
#(
  parameter int ENTRIES    = KVT_ENTRIES,
  parameter int KEY_BITS   = KVT_KEY_BITS,
  parameter int VALUE_BITS = KVT_VALUE_BITS,
  localparam int IDX_W     = $clog2(ENTRIES)
) (
  input  logic                   clk,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [IDX_W-1:0]       wr_addr,
  input  kvt_wr_t                wr,
  input  logic [KVT_FIELD_W-1:0] req_key,
  output kvt_cmp_t               cmp,
  output logic [VALUE_BITS-1:0]  rd_value
);

  // Top bit of a tag word is the valid mark.
  logic [KEY_BITS:0]     tag_mem_r [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem_r [ENTRIES];
  logic [KEY_BITS:0]     tag_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  always_ff @(posedge clk) begin
    if (wr.tag_en) begin
      tag_mem_r[wr_addr] <= {wr.valid, wr.key[KEY_BITS-1:0]};
    end
    if (wr.val_en) begin
      val_mem_r[wr_addr] <= wr.value[VALUE_BITS-1:0];
    end
    tag_rd_r <= tag_mem_r[rd_addr];
    val_rd_r <= val_mem_r[rd_addr];
  end

  always_comb begin
    cmp.free = !tag_rd_r[KEY_BITS];
    cmp.hit  = tag_rd_r[KEY_BITS] && (tag_rd_r[KEY_BITS-1:0] == req_key[KEY_BITS-1:0]);
  end

  assign rd_value = val_rd_r;

endmodule

// File: src/key_value_table_top.sv
// ----------------------------------------------------------------------------
// key_value_table_top
// Fully associative key/value table: set, get and delete by linear scan.
//
// Steps: the entries are read and compared in order; a request that hits
// stops the scan at that entry, a miss or a set into a free entry scans them all.
// One request at a time: new requests wait while the single read port of the
// entry store is scanned one entry per cycle and the result is presented.
// Reset: a clearing pass marks every entry invalid; no request is taken
// until it ends.
// ----------------------------------------------------------------------------
module key_value_table_top
  import kvt_pkg::*;
#(
  parameter int ENTRIES    = KVT_ENTRIES,
  parameter int KEY_BITS   = KVT_KEY_BITS,
  parameter int VALUE_BITS = KVT_VALUE_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_func,
  input  logic [KVT_FIELD_W-1:0] in_key,
  input  logic [KVT_FIELD_W-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_ok,
  output logic [KVT_FIELD_W-1:0] out_read_value
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   issue_done_r;
  logic                   cmp_live_r;
  logic                   cmp_last_r;
  logic [IDX_W-1:0]       cmp_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       slot_r;
  logic                   free_seen_r;
  logic [IDX_W-1:0]       free_slot_r;
  logic [1:0]             func_r;
  logic [KVT_FIELD_W-1:0] key_r;
  logic [KVT_FIELD_W-1:0] value_r;
  logic [VALUE_BITS-1:0]  hit_value_r;
  logic                   out_valid_r;
  logic                   out_ok_r;
  logic [KVT_FIELD_W-1:0] out_read_value_r;

  kvt_wr_t               wr;
  logic [IDX_W-1:0]      wr_addr;
  kvt_cmp_t              cmp;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  out_free;
  logic                  ok_c;
  logic [KVT_FIELD_W-1:0] rv_c;

  kvt_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_idx_r),
    .wr_addr  (wr_addr),
    .wr       (wr),
    .req_key  (key_r),
    .cmp      (cmp),
    .rd_value (rd_value)
  );

  assign out_free = !out_valid_r || !out_stall;

  // Outcome of the request and the store write it causes; also the clearing writes.
  always_comb begin
    ok_c     = 1'b0;
    rv_c     = '0;
    wr.tag_en = 1'b0;
    wr.val_en = 1'b0;
    wr.valid  = 1'b0;
    wr.key    = key_r;
    wr.value  = value_r;
    wr_addr   = found_r ? slot_r : free_slot_r;
    if (state_r == S_CLEAR) begin
      wr.tag_en = 1'b1;
      wr_addr   = rd_idx_r;
    end else if (state_r == S_FINISH) begin
      case (func_r)
        KVT_SET: begin
          ok_c      = found_r || free_seen_r;
          wr.tag_en = ok_c && out_free;
          wr.val_en = ok_c && out_free;
          wr.valid  = 1'b1;
        end
        KVT_GET: begin
          ok_c = found_r;
          rv_c = found_r ? KVT_FIELD_W'(hit_value_r) : '0;
        end
        KVT_DEL: begin
          ok_c      = found_r;
          wr.tag_en = found_r && out_free;
        end
        default: begin
          ok_c = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      rd_idx_r     <= '0;
      issue_done_r <= 1'b0;
      cmp_live_r   <= 1'b0;
      found_r      <= 1'b0;
      free_seen_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          rd_idx_r <= rd_idx_r + 1'b1;
          if (rd_idx_r == LAST_IDX) begin
            rd_idx_r <= '0;
            state_r  <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            func_r       <= in_func;
            key_r        <= in_key;
            value_r      <= in_value;
            rd_idx_r     <= '0;
            issue_done_r <= 1'b0;
            cmp_live_r   <= 1'b0;
            found_r      <= 1'b0;
            free_seen_r  <= 1'b0;
            state_r      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // The comparison of an entry follows its read issue in the next cycle.
          cmp_live_r <= !issue_done_r;
          cmp_last_r <= (rd_idx_r == LAST_IDX);
          cmp_idx_r  <= rd_idx_r;
          if (!issue_done_r) begin
            if (rd_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              rd_idx_r <= rd_idx_r + 1'b1;
            end
          end
          if (cmp_live_r) begin
            if (cmp.hit) begin
              found_r     <= 1'b1;
              slot_r      <= cmp_idx_r;
              hit_value_r <= rd_value;
              state_r     <= S_FINISH;
            end else begin
              if (cmp.free && !free_seen_r) begin
                free_seen_r <= 1'b1;
                free_slot_r <= cmp_idx_r;
              end
              if (cmp_last_r) begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r      <= 1'b1;
            out_ok_r         <= ok_c;
            out_read_value_r <= rv_c;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;

  // A result is only withdrawn by a transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result withdrawn without a transfer");

  // A failed request never carries a value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_read_value_r == '0)
    else $error("failed request carries a value");

  // Leaving the finish state always presents a result.
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_free |=> out_valid_r && state_r == S_IDLE)
    else $error("finished request produced no result");

  // The store is only written while clearing or when a request completes.
  a_wr_when: assert property (@(posedge clk) disable iff (!rst_n)
    wr.tag_en |-> state_r == S_CLEAR || (state_r == S_FINISH && out_free))
    else $error("store written outside clear or completion");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key/value table. A short table of directed
// requests covers the empty table, the extreme keys and values, overwrite,
// delete and the unknown operation code. Random requests follow, drawn from
// small key pools so that most of them hit, with a pass that fills the table
// past its capacity. Every answer is checked against the row's own answer
// where one is written, else against a behavioural copy of the table, under
// random idle gaps on the request side and random stalls on the answer side.
// ----------------------------------------------------------------------------
module tb_top
  import kvt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [KVT_FIELD_W-1:0] word_t;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         TAIL_CYCLES  = KVT_ENTRIES + 16;
  localparam int         DIR_ROWS     = 23;
  localparam int         POOL_SIZE    = 96;

  localparam word_t KEY_MASK   = (KVT_KEY_BITS >= KVT_FIELD_W) ? '1 :
                                 ((word_t'(1) << KVT_KEY_BITS) - 1);
  localparam word_t VALUE_MASK = (KVT_VALUE_BITS >= KVT_FIELD_W) ? '1 :
                                 ((word_t'(1) << KVT_VALUE_BITS) - 1);
  localparam word_t ONES       = '1;
  localparam word_t TOP_BIT    = word_t'(1) << (KVT_FIELD_W - 1);

  // One request; where known is set, the answer is written into the row.
  typedef struct packed {
    logic [1:0] func;
    word_t      key;
    word_t      value;
    logic       known;
    logic       exp_ok;
    word_t      exp_rv;
  } request_t;

  typedef struct packed {
    logic  ok;
    word_t rv;
  } answer_t;

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  out_ok;
  word_t out_read_value;

  request_t cur_req;

  // Behavioural copy of the table.
  logic  slot_used [KVT_ENTRIES] = '{default: 1'b0};
  word_t slot_key  [KVT_ENTRIES] = '{default: '0};
  word_t slot_val  [KVT_ENTRIES] = '{default: '0};

  answer_t  pending_answers [$];
  request_t requests [$];
  request_t directed_rows [DIR_ROWS];
  word_t    key_pool [POOL_SIZE];

  int  errors = 0;
  int  idle_cycles = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  timed_out;

  key_value_table_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (cur_req.func),
    .in_key         (cur_req.key),
    .in_value       (cur_req.value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_read_value (out_read_value)
  );

  always #10 clk = ~clk;

  // Most gaps are short; now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t random_word();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return ONES;
    return {$urandom, $urandom};
  endfunction

  function automatic request_t random_request(input int pool_span);
    request_t req;
    int       r;
    req = '0;
    r = $urandom_range(99);
    if (r < 45)      req.func = KVT_SET;
    else if (r < 78) req.func = KVT_GET;
    else if (r < 97) req.func = KVT_DEL;
    else             req.func = FUNC_UNKNOWN;
    if ($urandom_range(99) < 88) req.key = key_pool[$urandom_range(pool_span - 1)];
    else                         req.key = random_word();
    req.value = random_word();
    return req;
  endfunction

  // Applies one request to the table copy and returns the answer it gives.
  function automatic answer_t apply_request(input logic [1:0] func, input word_t key,
                                            input word_t value);
    answer_t ans;
    int      hit;
    int      slot;
    ans = '0;
    hit = -1;
    slot = -1;
    key = key & KEY_MASK;
    value = value & VALUE_MASK;
    for (int i = 0; i < KVT_ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
    end
    case (func)
      KVT_SET: begin
        // A matching key is overwritten in place, even if a lower entry is free.
        slot = hit;
        for (int i = 0; i < KVT_ENTRIES; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
        if (slot >= 0) begin
          slot_used[slot] = 1'b1;
          slot_key[slot] = key;
          slot_val[slot] = value;
          ans.ok = 1'b1;
        end
      end
      KVT_GET: begin
        if (hit >= 0) begin
          ans.ok = 1'b1;
          ans.rv = slot_val[hit];
        end
      end
      KVT_DEL: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          ans.ok = 1'b1;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Answer checking, request capture and the idle watchdog.
  always @(posedge clk) begin
    answer_t exp;
    answer_t got;
    bit      moved;
    moved = 1'b0;
    cycle_count <= cycle_count + 1;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      moved = 1'b1;
      if (pending_answers.size() == 0) begin
        $display("%0t: answer with none expected: ok %b read_value %h",
                 $time, out_ok, out_read_value);
        errors++;
      end else begin
        exp = pending_answers.pop_front();
        if (out_ok !== exp.ok) begin
          $display("%0t: ok mismatch: expected %b, got %b", $time, exp.ok, out_ok);
          errors++;
        end
        if (out_read_value !== exp.rv) begin
          $display("%0t: read_value mismatch: expected %h, got %h",
                   $time, exp.rv, out_read_value);
          errors++;
        end
      end
    end
    if (in_valid === 1'b1 && in_stall === 1'b0) begin
      moved = 1'b1;
      got = apply_request(cur_req.func, cur_req.key, cur_req.value);
      if (cur_req.known) begin
        exp.ok = cur_req.exp_ok;
        exp.rv = cur_req.exp_rv;
        pending_answers.push_back(exp);
      end else begin
        pending_answers.push_back(got);
      end
    end
    if (moved) idle_cycles <= 0;
    else       idle_cycles <= idle_cycles + 1;
  end

  // Answer-side stalls, with calm stretches where no new stall starts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ((cycle_count / 2000) % 4 != 1 && $urandom_range(3) == 0) stall_left <= idle_len();
    end
  end

  initial begin
    int gap;

    rst_n = 1'b0;
    in_valid = 1'b0;
    cur_req = '0;
    timed_out = 1'b0;

    // func, key, value, known, ok, read_value
    directed_rows = '{
      '{KVT_GET,      '0,      '0,      1'b1, 1'b0, '0},
      '{KVT_DEL,      ONES,    '0,      1'b1, 1'b0, '0},
      '{FUNC_UNKNOWN, '0,      ONES,    1'b1, 1'b0, '0},
      '{KVT_SET,      '0,      ONES,    1'b1, 1'b1, '0},
      '{KVT_GET,      '0,      '0,      1'b1, 1'b1, ONES},
      '{KVT_SET,      ONES,    '0,      1'b1, 1'b1, '0},
      '{KVT_GET,      ONES,    ONES,    1'b1, 1'b1, '0},
      '{KVT_SET,      '0,      64'h5555_5555_5555_5555, 1'b1, 1'b1, '0},
      '{KVT_GET,      '0,      '0,      1'b1, 1'b1, 64'h5555_5555_5555_5555},
      '{FUNC_UNKNOWN, '0,      '0,      1'b1, 1'b0, '0},
      '{KVT_GET,      '0,      '0,      1'b1, 1'b1, 64'h5555_5555_5555_5555},
      '{KVT_DEL,      '0,      '0,      1'b1, 1'b1, '0},
      '{KVT_GET,      '0,      '0,      1'b1, 1'b0, '0},
      '{KVT_DEL,      '0,      '0,      1'b1, 1'b0, '0},
      '{KVT_SET,      ONES,    64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, '0},
      '{KVT_GET,      ONES,    '0,      1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA},
      '{KVT_DEL,      ONES,    '0,      1'b1, 1'b1, '0},
      '{KVT_GET,      ONES,    '0,      1'b1, 1'b0, '0},
      '{KVT_SET,      TOP_BIT, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, '0},
      '{KVT_SET,      64'h1,   64'hFEDC_BA98_7654_3210, 1'b0, 1'b0, '0},
      '{KVT_GET,      TOP_BIT, '0,      1'b0, 1'b0, '0},
      '{KVT_GET,      64'h1,   '0,      1'b0, 1'b0, '0},
      '{KVT_DEL,      64'h1,   '0,      1'b0, 1'b0, '0}
    };

    key_pool[0] = '0;
    key_pool[1] = ONES;
    key_pool[2] = TOP_BIT;
    key_pool[3] = 64'h1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    foreach (directed_rows[i]) requests.push_back(directed_rows[i]);
    // A busy mix over a few keys, then enough distinct sets to overfill the
    // table, a mix over a wide pool while it stays near full, and a busy
    // mix again.
    repeat (230) requests.push_back(random_request(20));
    for (int i = 0; i < KVT_ENTRIES + 8; i++) begin
      request_t req;
      req = '0;
      req.func = KVT_SET;
      req.key = key_pool[i];
      req.value = random_word();
      requests.push_back(req);
    end
    repeat (150) requests.push_back(random_request(POOL_SIZE));
    repeat (180) requests.push_back(random_request(12));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    fork
      begin
        foreach (requests[i]) begin
          gap = ((i / 50) % 4 == 3) ? 0 : idle_len();
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          in_valid <= 1'b1;
          cur_req <= requests[i];
          do @(posedge clk); while (in_stall !== 1'b0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
      end
      begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        timed_out = 1'b1;
      end
    join_any

    if (!timed_out && errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/kvt_pkg.sv
src/kvt_store.sv
src/key_value_table_top.sv
dv/tb_top.sv
